FILE: hw/rtl/rws_pkg.sv
// Shared types and constants for the roulette wheel selector.
package rws_pkg;

   localparam int unsigned IDX_W    = 6;
   localparam int unsigned WEIGHT_W = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned TOTAL_W  = 38;
   localparam int unsigned TOT_LO_W = 32;
   localparam int unsigned TOT_HI_W = TOTAL_W - TOT_LO_W;
   localparam int unsigned PLO_W    = FRAC_W + TOT_LO_W;
   localparam int unsigned PHI_W    = FRAC_W + TOT_HI_W;
   localparam int unsigned PROD_W   = FRAC_W + TOTAL_W;
   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_WALK,
      ST_RESULT
   } rws_state_type;

   typedef struct packed {
      logic capture;   // latch fraction and total of a select item
      logic write;     // store the weight of a write item
      logic mul;       // form partial products
      logic sum;       // form target, restart the walk
      logic walk;      // step through the table
      logic load_rsp;  // move the result into the output register
   } rws_cmd_type;

   typedef struct packed {
      logic walk_done; // entry matched or last entry compared
      logic rsp_free;  // output register can take a result
   } rws_status_type;

endpackage

FILE: hw/rtl/rws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rws_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/rws_ctrl.sv
// Controller state machine for the roulette wheel selector.
module rws_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_command,
   output logic                    req_tready,
   input  rws_pkg::rws_status_type status,
   output rws_pkg::rws_cmd_type    cmd
);

   import rws_pkg::*;

   rws_state_type state_ff;
   rws_state_type state_in;
   logic          accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_SELECT)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_WALK;
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = accept && (req_command == CMD_SELECT);
            cmd.write   = accept && (req_command == CMD_WRITE);
         end
         ST_MUL:    cmd.mul = 1'b1;
         ST_SUM:    cmd.sum = 1'b1;
         ST_WALK:   cmd.walk = 1'b1;
         ST_RESULT: cmd.load_rsp = status.rsp_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/rws_datapath.sv
// Datapath: target scaling, weight table walk and output register.
module rws_datapath #(
   parameter int unsigned POPULATION = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rws_pkg::rws_cmd_type              cmd,
   output rws_pkg::rws_status_type           status,
   input  logic [rws_pkg::IDX_W-1:0]         entry_index,
   input  logic [rws_pkg::WEIGHT_W-1:0]      weight,
   input  logic [rws_pkg::FRAC_W-1:0]        random_fraction,
   input  logic [rws_pkg::TOTAL_W-1:0]       total_weight,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rws_pkg::IDX_W-1:0]         chosen_index,
   output logic                              fell_through
);

   import rws_pkg::*;

   localparam int unsigned AW = $clog2(POPULATION);
   localparam logic [AW-1:0] LAST = AW'(POPULATION - 1);

   logic [FRAC_W-1:0]   frac_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [PLO_W-1:0]    plo_ff;
   logic [PHI_W-1:0]    phi_ff;
   logic [PROD_W-1:0]   product;
   logic [TOTAL_W-1:0]  target_ff;
   logic [TOTAL_W-1:0]  target_in;
   logic [AW-1:0]       addr_ff;
   logic [AW-1:0]       addr_in;
   logic [AW-1:0]       cmp_idx_ff;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic [WEIGHT_W-1:0] rd_data;
   logic [TOTAL_W-1:0]  entry_w;
   logic                hit;
   logic                last;
   logic                wr_ok;
   logic [IDX_W-1:0]    res_idx_ff;
   logic                res_fell_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic                rsp_fell_ff;

   // writes beyond the table are dropped
   assign wr_ok = cmd.write && (32'(entry_index) < 32'(POPULATION));

   rws_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (POPULATION)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_ok),
      .wr_addr    (AW'(entry_index)),
      .wr_data    (weight),
      .rd_en      (cmd.walk),
      .rd_addr    (addr_ff),
      .rd_data_ff (rd_data)
   );

   // total split into 32 low and 6 high bits, summed the next cycle
   assign product = PROD_W'(plo_ff) + {phi_ff, {TOT_LO_W{1'b0}}};

   assign entry_w = TOTAL_W'(rd_data);
   assign hit     = rd_valid_ff && (target_ff < entry_w);
   assign last    = rd_valid_ff && (cmp_idx_ff == LAST);

   always_comb begin
      target_in   = target_ff;
      addr_in     = addr_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.sum) begin
         target_in   = product[PROD_W-1:FRAC_W];
         addr_in     = '0;
         rd_valid_in = 1'b0;
      end else if (cmd.walk) begin
         rd_valid_in = 1'b1;
         if (addr_ff != LAST) begin
            addr_in = addr_ff + AW'(1);
         end
         if (rd_valid_ff && !hit) begin
            target_in = target_ff - entry_w;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         frac_ff  <= random_fraction;
         total_ff <= total_weight;
      end
      if (cmd.mul) begin
         plo_ff <= PLO_W'(frac_ff) * PLO_W'(total_ff[TOT_LO_W-1:0]);
         phi_ff <= PHI_W'(frac_ff) * PHI_W'(total_ff[TOTAL_W-1:TOT_LO_W]);
      end
      target_ff  <= target_in;
      addr_ff    <= addr_in;
      cmp_idx_ff <= addr_ff;
      if (cmd.walk && (hit || last)) begin
         res_idx_ff  <= IDX_W'(cmp_idx_ff);
         res_fell_ff <= !hit;
      end
      if (cmd.load_rsp) begin
         rsp_idx_ff  <= res_idx_ff;
         rsp_fell_ff <= res_fell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.walk_done = hit || last;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign chosen_index = rsp_idx_ff;
   assign fell_through = rsp_fell_ff;

endmodule

FILE: hw/rtl/roulette_wheel_select.sv
// Roulette wheel selector top level: stream ports, controller and datapath.
//
// Input channel req_*: tuser is the command (write weight or select).
// A write stores weight at entry_index and gives no result. A select
// scales random_fraction by total_weight and walks the weight table,
// one entry per cycle, returning the first index whose weight exceeds
// the remaining target, or the last index with fell_through set.
// Result channel rsp_*: one item per select.
// The next item is taken only after a select's result has moved into the
// output register; req_tready is high only while the controller is idle.
// The walk rate is set by the single table read port (one entry a cycle,
// registered read data).
// Reset clears control state only; table entries are undefined until written.
// A stalled receiver holds the result in the output register; writes are
// still taken, and a following select waits at its end until the register
// empties.
module roulette_wheel_select #(
   parameter int unsigned POPULATION = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index[5:0], weight[37:6], random_fraction[53:38],
   // total_weight[91:54], zero pad
   input  logic [rws_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // chosen_index[5:0], zero pad
   output logic [rws_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // fell_through[0]
   output logic                              rsp_tuser
);

   import rws_pkg::*;

   rws_cmd_type      cmd;
   rws_status_type   status;
   logic [IDX_W-1:0] chosen_index;

   rws_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   rws_datapath #(
      .POPULATION (POPULATION)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .entry_index     (req_tdata[5:0]),
      .weight          (req_tdata[37:6]),
      .random_fraction (req_tdata[53:38]),
      .total_weight    (req_tdata[91:54]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .chosen_index    (chosen_index),
      .fell_through    (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(chosen_index);

endmodule

FILE: sim/tb_roulette_wheel_select.sv
// Testbench for roulette_wheel_select: stream driver, response sink and pick scoreboard.
module tb_roulette_wheel_select;
   import rws_pkg::*;

   localparam int unsigned POPULATION    = 64;
   localparam int unsigned PHASE_ITEMS   = 240;
   localparam int unsigned HOLD_ITEMS    = 80;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned DRAIN_CYCLES  = POPULATION + 10;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam longint unsigned CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [IDX_W-1:0] chosen;
      logic             fell;
   } pick_type;

   typedef enum int {
      SCALE_ZERO,
      SCALE_TINY,
      SCALE_HALF,
      SCALE_FULL,
      SCALE_TOP
   } weight_scale_type;

   // Tracks the weight table as seen through accepted items and predicts each pick.
   class selection_scoreboard;
      logic [WEIGHT_W-1:0]   weights [POPULATION];
      pick_type              expected_picks [$];
      int unsigned           errors;
      int unsigned           writes;
      int unsigned           selects;
      int unsigned           fallthroughs;
      logic [POPULATION-1:0] indices_seen;

      function new();
         foreach (weights[i]) weights[i] = '0;
         errors       = 0;
         writes       = 0;
         selects      = 0;
         fallthroughs = 0;
         indices_seen = '0;
      endfunction

      function void note_item(logic command, logic [IDX_W-1:0] index,
                              logic [WEIGHT_W-1:0] weight, logic [FRAC_W-1:0] fraction,
                              logic [TOTAL_W-1:0] total);
         logic [63:0] remaining;
         pick_type    pick;
         if (command == CMD_WRITE) begin
            if (index < POPULATION) weights[index] = weight;
            writes++;
            return;
         end
         // target = floor(fraction * total / 2^16); the walk never wraps it
         remaining   = (64'(fraction) * 64'(total)) >> FRAC_W;
         pick.chosen = IDX_W'(POPULATION - 1);
         pick.fell   = 1'b1;
         for (int i = 0; i < POPULATION; i++) begin
            if (remaining < 64'(weights[i])) begin
               pick.chosen = IDX_W'(i);
               pick.fell   = 1'b0;
               break;
            end
            remaining -= 64'(weights[i]);
         end
         selects++;
         if (pick.fell) fallthroughs++;
         expected_picks.push_back(pick);
      endfunction

      function void check_pick(logic [IDX_W-1:0] chosen, logic fell);
         pick_type want;
         if (expected_picks.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected pick: index %0d fell_through %0b", chosen, fell);
            return;
         end
         want = expected_picks.pop_front();
         if (chosen !== want.chosen || fell !== want.fell) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"pick mismatch: expected index %0d fell_through %0b, ",
                         "got index %0d fell_through %0b"},
                        want.chosen, want.fell, chosen, fell);
         end else begin
            indices_seen[want.chosen] = 1'b1;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   selection_scoreboard   board;
   logic [WEIGHT_W-1:0]   stim_weights [POPULATION];
   weight_scale_type      weight_scale;
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           items_sent = 0;
   bit                    hold_go = 1'b0;
   bit                    hold_active = 1'b0;
   longint unsigned       cycle_count = 0;

   roulette_wheel_select #(
      .POPULATION(POPULATION)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[roulette_wheel_select] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_item(req_tuser, req_tdata[5:0], req_tdata[37:6], req_tdata[53:38],
                            req_tdata[91:54]);
         if (rsp_tvalid && rsp_tready)
            board.check_pick(rsp_tdata[5:0], rsp_tuser);
      end
   end

   always @(negedge clock)
      rsp_tready <= !hold_active && ($urandom_range(99) >= rsp_stall_pct);

   // long output hold, counted here so the sender keeps pushing meanwhile
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   function automatic logic [TOTAL_W-1:0] random_total();
      return TOTAL_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [TOTAL_W-1:0] table_sum();
      logic [TOTAL_W-1:0] sum;
      sum = '0;
      foreach (stim_weights[i]) sum += TOTAL_W'(stim_weights[i]);
      return sum;
   endfunction

   function automatic logic [WEIGHT_W-1:0] draw_weight();
      if (weight_scale != SCALE_ZERO && $urandom_range(15) == 0)
         return $urandom_range(1) ? {WEIGHT_W{1'b1}} : '0;
      case (weight_scale)
         SCALE_ZERO: return '0;
         SCALE_TINY: return WEIGHT_W'($urandom_range(15));
         SCALE_HALF: return WEIGHT_W'($urandom_range(65535));
         SCALE_FULL: return WEIGHT_W'($urandom());
         default:    return WEIGHT_W'(32'hFFFF_FFFF - $urandom_range(255));
      endcase
   endfunction

   // entered just after a falling edge, returns just after one
   task automatic send_item(logic command, logic [IDX_W-1:0] index,
                            logic [WEIGHT_W-1:0] weight, logic [FRAC_W-1:0] fraction,
                            logic [TOTAL_W-1:0] total);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= command;
      req_tdata  <= REQ_DATA_W'({total, fraction, weight, index});
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
      items_sent++;
   endtask

   // unused fields of each item carry random filler
   task automatic write_weight(logic [IDX_W-1:0] index, logic [WEIGHT_W-1:0] weight);
      stim_weights[index] = weight;
      send_item(CMD_WRITE, index, weight, FRAC_W'($urandom()), random_total());
   endtask

   task automatic select_pick(logic [FRAC_W-1:0] fraction, logic [TOTAL_W-1:0] total);
      send_item(CMD_SELECT, IDX_W'($urandom()), WEIGHT_W'($urandom()), fraction, total);
   endtask

   task automatic refill_table();
      for (int i = 0; i < POPULATION; i++) write_weight(IDX_W'(i), draw_weight());
   endtask

   task automatic random_sequence();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 2) begin
         weight_scale = weight_scale_type'($urandom_range(SCALE_TOP));
         refill_table();
         select_pick(FRAC_W'($urandom()), table_sum());
      end else if (kind < 50) begin
         repeat ($urandom_range(2)) write_weight(IDX_W'($urandom()), draw_weight());
         select_pick(FRAC_W'($urandom()), table_sum());
      end else if (kind < 62) begin
         // total above the stored sum: high fractions fall through
         select_pick(FRAC_W'($urandom()),
                     table_sum() + TOTAL_W'($urandom_range(1, 1 << 20)));
      end else if (kind < 72) begin
         select_pick($urandom_range(1) ? {FRAC_W{1'b1}} : '0, table_sum());
      end else if (kind < 82) begin
         select_pick(FRAC_W'($urandom()), random_total());
      end else if (kind < 92) begin
         repeat ($urandom_range(1, 4)) write_weight(IDX_W'($urandom()), draw_weight());
      end else if (kind < 96) begin
         select_pick(FRAC_W'($urandom()), '0);
      end else begin
         select_pick(FRAC_W'($urandom()), {TOTAL_W{1'b1}});
      end
   endtask

   initial begin
      int unsigned idle_by_phase  [4];
      int unsigned stall_by_phase [4];
      int unsigned phase_end;
      idle_by_phase  = '{0, 81, 0, 38};
      stall_by_phase = '{0, 0, 81, 38};
      board = new();
      foreach (stim_weights[i]) stim_weights[i] = '0;
      weight_scale = SCALE_HALF;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every entry is written before any select can reach it
      refill_table();

      write_weight(IDX_W'(0), '0);
      write_weight(IDX_W'(1), '0);
      write_weight(IDX_W'(2), '1);
      write_weight(IDX_W'(63), '1);
      select_pick('0, '0);                  // zero target skips leading zero entries
      select_pick('1, '0);
      select_pick('0, '1);
      select_pick('1, '1);
      select_pick('1, table_sum());         // lands at the heavy last entry
      select_pick(16'h8000, table_sum());
      select_pick(16'h0001, table_sum());
      write_weight(IDX_W'(2), 32'd1);
      select_pick('0, '0);
      select_pick('1, '1);                  // target past the whole table
      select_pick(16'h7FFF, table_sum() >> 1);
      write_weight(IDX_W'(63), '0);
      select_pick('1, '1);

      // all-zero table: zero total still falls through
      weight_scale = SCALE_ZERO;
      refill_table();
      select_pick('0, '0);
      select_pick('1, '1);
      weight_scale = SCALE_HALF;
      refill_table();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_by_phase[phase];
         rsp_stall_pct = stall_by_phase[phase];
         phase_end     = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_sequence();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_go       = 1'b1;
      phase_end     = items_sent + HOLD_ITEMS;
      while (items_sent < phase_end) random_sequence();

      req_tvalid <= 1'b0;
      while (board.expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d weight writes and %0d selects (%0d fell through), %0d %s",
               board.writes, board.selects, board.fallthroughs,
               $countones(board.indices_seen), "distinct indices picked.");
      $display("Ran with sender gaps, receiver stalls and one %0d-cycle output hold; %0d %s",
               HOLD_CYCLES, board.errors, "mismatches.");
      if (board.errors == 0 && board.expected_picks.size() == 0)
         $display("[roulette_wheel_select] OK");
      else
         $display("[roulette_wheel_select] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rws_pkg.sv
hw/rtl/rws_ram.sv
hw/rtl/rws_ctrl.sv
hw/rtl/rws_datapath.sv
hw/rtl/roulette_wheel_select.sv
sim/tb_roulette_wheel_select.sv
